@@ design/fxalu_pkg.sv @@
// Shared constants, opcodes and pipeline stage type for the Q24.8 fixed-point ALU.
`default_nettype none
package fxalu_pkg;
	localparam int WORD_W   = 32;
	localparam int FRAC_W   = 8;
	localparam int NUM_W    = WORD_W + FRAC_W;
	localparam int REM_W    = WORD_W + 1;
	localparam int PROD_W   = 2 * WORD_W;
	localparam int MAG_W    = PROD_W - FRAC_W + 1;
	localparam int NSTAGE   = NUM_W + 3;
	localparam int RND_IDX  = NUM_W + 1;
	localparam int FIN_IDX  = NUM_W + 2;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
		OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_OVERFLOW = 2'd1, ST_DIV_ZERO = 2'd2
	} status_t;

	typedef struct packed {
		op_t               op;
		logic              neg;
		logic              dz;
		logic [WORD_W-1:0] dvs;
		logic [NUM_W-1:0]  num;
		logic [REM_W-1:0]  rem;
		logic [NUM_W-1:0]  quo;
		logic [PROD_W-1:0] prod;
		logic [MAG_W-1:0]  mag;
		logic [WORD_W-1:0] res;
		logic              cmp;
		status_t           status;
	} stage_t;
endpackage
`default_nettype wire

@@ design/fxalu_div_step.sv @@
// One restoring division step: shift in a numerator bit, trial subtract, record a quotient bit.
`default_nettype none
module fxalu_div_step (
	input  wire logic [fxalu_pkg::WORD_W-1:0] dvs,
	input  wire logic [fxalu_pkg::REM_W-1:0]  rem_i,
	input  wire logic [fxalu_pkg::NUM_W-1:0]  num_i,
	input  wire logic [fxalu_pkg::NUM_W-1:0]  quo_i,
	output logic      [fxalu_pkg::REM_W-1:0]  rem_o,
	output logic      [fxalu_pkg::NUM_W-1:0]  num_o,
	output logic      [fxalu_pkg::NUM_W-1:0]  quo_o
);
	logic [fxalu_pkg::REM_W-1:0] trial;
	logic [fxalu_pkg::REM_W-1:0] dext;
	logic                        ge;

	always_comb begin
		trial = {rem_i[fxalu_pkg::REM_W-2:0], num_i[fxalu_pkg::NUM_W-1]};
		dext  = {1'b0, dvs};
		ge    = trial >= dext;
		rem_o = ge ? (trial - dext) : trial;
		num_o = {num_i[fxalu_pkg::NUM_W-2:0], 1'b0};
		quo_o = {quo_i[fxalu_pkg::NUM_W-2:0], ge};
	end
endmodule
`default_nettype wire

@@ design/fixed_point_alu_q24_8_top.sv @@
// Top level of the pipelined Q24.8 fixed-point ALU.
// Every opcode passes through all stages: input, the divider steps, rounding and finishing.
// One operation per cycle unless stalled; the divider is unrolled into 40 restoring stages.
// Each stage advances when the next one is empty or advancing, so bubbles close up under stall.
// Reset clears all stage valid bits; payload registers are not reset.
`default_nettype none
module fixed_point_alu_q24_8_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_stall,
	input  wire logic [3:0]                         cmd,
	input  wire logic signed [fxalu_pkg::WORD_W-1:0] operand_a,
	input  wire logic signed [fxalu_pkg::WORD_W-1:0] operand_b,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_stall,
	output logic signed [fxalu_pkg::WORD_W-1:0]      result_value,
	output logic                                    compare_true,
	output logic [1:0]                              status
);
	localparam int W = fxalu_pkg::WORD_W;
	localparam int N = fxalu_pkg::NSTAGE;

	fxalu_pkg::stage_t pipe_q [N];
	fxalu_pkg::stage_t nxt    [N];
	logic [N-1:0]      vld_q;
	logic [N-1:0]      adv;

	always_comb begin
		adv[N-1] = !vld_q[N-1] || !rsp_stall;
		for (int i = N - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign req_stall = !adv[0];

	logic [W-1:0] mag_a, mag_b;
	logic         lt_ab, lt_ba;

	always_comb begin
		mag_a = operand_a[W-1] ? (W'(0) - operand_a) : operand_a;
		mag_b = operand_b[W-1] ? (W'(0) - operand_b) : operand_b;
		lt_ab = operand_a < operand_b;
		lt_ba = operand_b < operand_a;
		nxt[0]        = '0;
		nxt[0].op     = fxalu_pkg::op_t'(cmd);
		nxt[0].neg    = operand_a[W-1] ^ operand_b[W-1];
		nxt[0].dz     = mag_b == '0;
		nxt[0].dvs    = mag_b;
		nxt[0].num    = {mag_a, {fxalu_pkg::FRAC_W{1'b0}}};
		nxt[0].status = fxalu_pkg::ST_OK;
		case (fxalu_pkg::op_t'(cmd))
			fxalu_pkg::OP_ADD:      nxt[0].res = operand_a + operand_b;
			fxalu_pkg::OP_SUB:      nxt[0].res = operand_a - operand_b;
			fxalu_pkg::OP_GT:       nxt[0].cmp = lt_ba;
			fxalu_pkg::OP_LT:       nxt[0].cmp = lt_ab;
			fxalu_pkg::OP_GE:       nxt[0].cmp = !lt_ab;
			fxalu_pkg::OP_LE:       nxt[0].cmp = !lt_ba;
			fxalu_pkg::OP_EQ:       nxt[0].cmp = operand_a == operand_b;
			fxalu_pkg::OP_NE:       nxt[0].cmp = operand_a != operand_b;
			fxalu_pkg::OP_MIN:      nxt[0].res = lt_ab ? operand_a : operand_b;
			fxalu_pkg::OP_MAX:      nxt[0].res = lt_ba ? operand_a : operand_b;
			fxalu_pkg::OP_INC:      nxt[0].res = operand_a + W'(1);
			fxalu_pkg::OP_DEC:      nxt[0].res = operand_a - W'(1);
			fxalu_pkg::OP_FROM_INT: nxt[0].res = operand_a << fxalu_pkg::FRAC_W;
			fxalu_pkg::OP_TO_INT:   nxt[0].res = operand_a >>> fxalu_pkg::FRAC_W;
			default:                nxt[0].res = '0;
		endcase
	end

	for (genvar k = 1; k <= fxalu_pkg::NUM_W; k++) begin : g_div
		logic [fxalu_pkg::REM_W-1:0] rem_n;
		logic [fxalu_pkg::NUM_W-1:0] num_n, quo_n;

		fxalu_div_step u_step (
			.dvs   (pipe_q[k-1].dvs),
			.rem_i (pipe_q[k-1].rem),
			.num_i (pipe_q[k-1].num),
			.quo_i (pipe_q[k-1].quo),
			.rem_o (rem_n),
			.num_o (num_n),
			.quo_o (quo_n)
		);

		always_comb begin
			nxt[k]     = pipe_q[k-1];
			nxt[k].rem = rem_n;
			nxt[k].num = num_n;
			nxt[k].quo = quo_n;
			if (k == 1) begin
				nxt[k].prod = pipe_q[0].num[fxalu_pkg::NUM_W-1 -: W] * pipe_q[0].dvs;
			end
		end
	end

	localparam int RI = fxalu_pkg::RND_IDX;
	localparam int FI = fxalu_pkg::FIN_IDX;

	logic [fxalu_pkg::PROD_W:0]  prod_rnd;
	logic [fxalu_pkg::NUM_W:0]   quo_rnd;
	logic                        up;

	always_comb begin
		prod_rnd = {1'b0, pipe_q[RI-1].prod}
			+ (fxalu_pkg::PROD_W+1)'(1 << (fxalu_pkg::FRAC_W - 1));
		up       = {pipe_q[RI-1].rem, 1'b0} >= {2'b00, pipe_q[RI-1].dvs};
		quo_rnd  = {1'b0, pipe_q[RI-1].quo} + (fxalu_pkg::NUM_W+1)'(up);
		nxt[RI]  = pipe_q[RI-1];
		if (pipe_q[RI-1].op == fxalu_pkg::OP_MUL) begin
			nxt[RI].mag = prod_rnd[fxalu_pkg::PROD_W:fxalu_pkg::FRAC_W];
		end else begin
			nxt[RI].mag = fxalu_pkg::MAG_W'(quo_rnd);
		end
	end

	logic [fxalu_pkg::MAG_W-1:0] limit;
	logic [W-1:0]                sat_val;

	always_comb begin
		limit   = pipe_q[FI-1].neg ? (fxalu_pkg::MAG_W'(1) << (W - 1))
			: ((fxalu_pkg::MAG_W'(1) << (W - 1)) - fxalu_pkg::MAG_W'(1));
		sat_val = pipe_q[FI-1].neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		nxt[FI] = pipe_q[FI-1];
		if (pipe_q[FI-1].op == fxalu_pkg::OP_DIV && pipe_q[FI-1].dz) begin
			nxt[FI].res    = '0;
			nxt[FI].status = fxalu_pkg::ST_DIV_ZERO;
		end else if (pipe_q[FI-1].op == fxalu_pkg::OP_MUL
				|| pipe_q[FI-1].op == fxalu_pkg::OP_DIV) begin
			if (pipe_q[FI-1].mag > limit) begin
				nxt[FI].res    = sat_val;
				nxt[FI].status = fxalu_pkg::ST_OVERFLOW;
			end else if (pipe_q[FI-1].neg) begin
				nxt[FI].res = W'(0) - pipe_q[FI-1].mag[W-1:0];
			end else begin
				nxt[FI].res = pipe_q[FI-1].mag[W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < N; i++) begin
				if (adv[i]) begin
					vld_q[i] <= (i == 0) ? req_valid : vld_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			if (adv[i]) begin
				pipe_q[i] <= nxt[i];
			end
		end
	end

	assign rsp_valid    = vld_q[N-1];
	assign result_value = pipe_q[N-1].res;
	assign compare_true = pipe_q[N-1].cmp;
	assign status       = pipe_q[N-1].status;
endmodule
`default_nettype wire

@@ design/fxalu_checker.sv @@
// Port-level assertions for the fixed-point ALU, bound to the top level.
`default_nettype none
module fxalu_assertions (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_stall,
	input wire logic [fxalu_pkg::WORD_W-1:0]  result_value,
	input wire logic                          compare_true,
	input wire logic [1:0]                    status
);
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == fxalu_pkg::ST_DIV_ZERO |-> result_value == '0)
		else $error("division by zero with nonzero result");

	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && compare_true |-> result_value == '0 && status == fxalu_pkg::ST_OK)
		else $error("compare result with nonzero value or status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status == fxalu_pkg::ST_OK || status == fxalu_pkg::ST_OVERFLOW
			|| status == fxalu_pkg::ST_DIV_ZERO)
		else $error("undefined status code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(result_value) && $stable(status))
		else $error("stalled transfer dropped or changed");
endmodule

bind fixed_point_alu_q24_8_top fxalu_assertions u_fxalu_assertions (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.result_value (result_value),
	.compare_true (compare_true),
	.status       (status)
);
`default_nettype wire

@@ bench/fxalu_checker.sv @@
// Checker for the Q24.8 fixed-point ALU: predicts each result and compares it.
`timescale 1ns / 1ps
`default_nettype none
module fxalu_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                req_valid,
	input  wire logic                                req_stall,
	input  wire logic [3:0]                          cmd,
	input  wire logic signed [fxalu_pkg::WORD_W-1:0] operand_a,
	input  wire logic signed [fxalu_pkg::WORD_W-1:0] operand_b,
	input  wire logic                                rsp_valid,
	input  wire logic                                rsp_stall,
	input  wire logic signed [fxalu_pkg::WORD_W-1:0] result_value,
	input  wire logic                                compare_true,
	input  wire logic [1:0]                          status,
	output int                                       fail_count,
	output int                                       pending,
	output int                                       result_count
);
	localparam int W  = fxalu_pkg::WORD_W;
	localparam int FW = fxalu_pkg::FRAC_W;

	typedef struct packed {
		logic [W-1:0]        value;
		logic                cmp;
		fxalu_pkg::status_t  st;
	} alu_result_t;

	alu_result_t expected_results[$];

	function automatic alu_result_t saturate(logic [127:0] mag, logic neg);
		alu_result_t r;
		logic [127:0] lim;
		r = '0;
		lim = neg ? (128'd1 << (W - 1)) : ((128'd1 << (W - 1)) - 1);
		if (mag > lim) begin
			r.st = fxalu_pkg::ST_OVERFLOW;
			r.value = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			r.st = fxalu_pkg::ST_OK;
			r.value = neg ? W'(-mag) : mag[W-1:0];
		end
		return r;
	endfunction

	function automatic alu_result_t compute_alu(fxalu_pkg::op_t op, logic signed [W-1:0] a,
			logic signed [W-1:0] b);
		alu_result_t r;
		logic [127:0] ma, mb, prod, num, quo, rem;
		logic neg;
		r = '0;
		r.st = fxalu_pkg::ST_OK;
		ma = a[W-1] ? 128'(-{{96{a[W-1]}}, a}) : 128'(a);
		mb = b[W-1] ? 128'(-{{96{b[W-1]}}, b}) : 128'(b);
		ma = ma & ((128'd1 << W) - 1) | (a == {1'b1, {(W-1){1'b0}}} ?
			(128'd1 << (W - 1)) : 128'd0);
		mb = mb & ((128'd1 << W) - 1) | (b == {1'b1, {(W-1){1'b0}}} ?
			(128'd1 << (W - 1)) : 128'd0);
		neg = a[W-1] ^ b[W-1];
		case (op)
			fxalu_pkg::OP_ADD: r.value = a + b;
			fxalu_pkg::OP_SUB: r.value = a - b;
			fxalu_pkg::OP_MUL: begin
				prod = ma * mb + (128'd1 << (FW - 1));
				r = saturate(prod >> FW, neg);
			end
			fxalu_pkg::OP_DIV: begin
				if (mb == 0) begin
					r.st = fxalu_pkg::ST_DIV_ZERO;
				end else begin
					num = ma << FW;
					quo = num / mb;
					rem = num % mb;
					if (rem >= mb - rem) quo = quo + 1;
					r = saturate(quo, neg);
				end
			end
			fxalu_pkg::OP_GT: r.cmp = a > b;
			fxalu_pkg::OP_LT: r.cmp = a < b;
			fxalu_pkg::OP_GE: r.cmp = a >= b;
			fxalu_pkg::OP_LE: r.cmp = a <= b;
			fxalu_pkg::OP_EQ: r.cmp = a == b;
			fxalu_pkg::OP_NE: r.cmp = a != b;
			fxalu_pkg::OP_MIN: r.value = (a < b) ? a : b;
			fxalu_pkg::OP_MAX: r.value = (b < a) ? a : b;
			fxalu_pkg::OP_INC: r.value = a + 1;
			fxalu_pkg::OP_DEC: r.value = a - 1;
			fxalu_pkg::OP_FROM_INT: r.value = a << FW;
			default: r.value = a >>> FW;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
		$display("MISMATCH %0t %s: got %h expected %h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		alu_result_t want;
		if (arst_n && req_valid && !req_stall)
			expected_results.push_back(compute_alu(fxalu_pkg::op_t'(cmd), operand_a,
				operand_b));
		if (arst_n && rsp_valid && !rsp_stall) begin
			result_count++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected transfer", result_value, '0);
			end else begin
				want = expected_results.pop_front();
				if (result_value !== want.value)
					report_mismatch("result_value", result_value, want.value);
				if (compare_true !== want.cmp)
					report_mismatch("compare_true", compare_true, want.cmp);
				if (status !== want.st)
					report_mismatch("status", status, want.st);
			end
		end
		pending = expected_results.size();
	end
endmodule
`default_nettype wire

@@ bench/tb_fixed_point_alu_q24_8_top.sv @@
// Testbench top for the Q24.8 fixed-point ALU: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_fixed_point_alu_q24_8_top;
	localparam int W = fxalu_pkg::WORD_W;
	localparam int LATENCY = 43;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic [3:0] cmd = '0;
	logic signed [W-1:0] operand_a = '0;
	logic signed [W-1:0] operand_b = '0;
	logic rsp_stall = 1'b0;
	logic req_stall, rsp_valid, compare_true;
	logic signed [W-1:0] result_value;
	logic [1:0] status;
	int fail_count, pending, result_count;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit running = 1'b1;

	fixed_point_alu_q24_8_top DUT (.*);

	fxalu_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		rsp_stall <= running && ($urandom_range(99) < recv_stall_pct);

	function automatic logic [W-1:0] pick_operand();
		case ($urandom_range(7))
			0: return {1'b1, {(W-1){1'b0}}};
			1: return {1'b0, {(W-1){1'b1}}};
			2: return W'($urandom_range(4)) - 2;
			3: return W'($signed($urandom_range(2047)) - 1024);
			4: return W'($signed($urandom_range(131071)) - 65536);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_op(fxalu_pkg::op_t op, logic [W-1:0] a, logic [W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		cmd <= op;
		operand_a <= a;
		operand_b <= b;
		do @(posedge clk); while (req_stall);
	endtask

	initial begin
		logic [W-1:0] edges [6];
		edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff, 32'h0000_0100};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int o = 0; o < 16; o++)
			send_op(fxalu_pkg::op_t'(o), edges[o % 6], edges[(o + 1) % 6]);
		send_op(fxalu_pkg::OP_DIV, 32'h0000_1234, 32'h0);
		send_op(fxalu_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
		send_op(fxalu_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
		send_op(fxalu_pkg::OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
		send_op(fxalu_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
		send_op(fxalu_pkg::OP_MUL, 32'h0000_0080, 32'h0000_0001);
		send_op(fxalu_pkg::OP_DIV, 32'hffff_ff80, 32'h0000_0200);
		send_op(fxalu_pkg::OP_TO_INT, 32'hffff_ff01, 32'h0);
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 48 : 8) : 0;
			recv_stall_pct = (phase == 2) ? 48 : ((phase == 3) ? 8 : 0);
			for (int i = 0; i < 480; i++)
				send_op(fxalu_pkg::op_t'($urandom_range(15)), pick_operand(),
					pick_operand());
		end
		req_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		running = 1'b0;
		repeat (LATENCY + 10) @(posedge clk);
		$display("Covered all 16 opcodes with edge and random operands, %0d results checked,",
			result_count);
		$display("under free flow, sender gaps, receiver stalls and both together.");
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
design/fxalu_pkg.sv
design/fxalu_div_step.sv
design/fixed_point_alu_q24_8_top.sv
design/fxalu_checker.sv
bench/fxalu_checker.sv
bench/tb_fixed_point_alu_q24_8_top.sv
